// File: hdl/htfv_pkg.sv
// Shared types, command codes and hash constants for the hashed text feature vector.
// No dependencies; the top and the testbench refer to this package by scoped names.
package htfv_pkg;

   localparam int CMD_W    = 2;
   localparam int BYTE_W   = 8;
   localparam int INDEX_W  = 12;
   localparam int VALUE_W  = 16;
   localparam int DIMS_W   = 13;
   localparam int HASH_W   = 32;
   localparam int ACC_W    = 32;
   localparam int WEIGHT_W = 17;
   localparam int SUM_W    = 64;

   typedef logic [HASH_W-1:0]   hash_type;
   typedef logic [ACC_W-1:0]    acc_type;
   typedef logic [WEIGHT_W-1:0] weight_type;

   localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_END   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

   localparam hash_type FNV_BASIS = 32'h811C9DC5;
   localparam hash_type FNV_PRIME = 32'h01000193;

   // Weights in Q1.16.
   localparam weight_type W_ONE     = 17'd65536;
   localparam weight_type W_BIGRAM  = 17'd45875;
   localparam weight_type W_TRIGRAM = 17'd19661;

   localparam logic [BYTE_W-1:0] CHAR_CARET      = 8'h5E;
   localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;

   localparam logic [DIMS_W-1:0] DIMS_RESET = 13'd384;

   function automatic hash_type fnv_step(input hash_type h, input logic [BYTE_W-1:0] b);
      logic [2*HASH_W-1:0] prod;
      prod = (h ^ {{(HASH_W-BYTE_W){1'b0}}, b}) * FNV_PRIME;
      return prod[HASH_W-1:0];
   endfunction

   // Pair hash seed for the first token of a text: "^_".
   localparam hash_type CARET_PAIR_HASH = fnv_step(fnv_step(FNV_BASIS, CHAR_CARET),
                                                   CHAR_UNDERSCORE);

endpackage

// File: hdl/hashed_text_feature_vector_top.sv
// Hashed text feature vector: tokenizes text bytes and accumulates FNV-1a feature terms,
// then L2-normalizes on end of text. Uses htfv_pkg and htfv_divider.
//
// Text arrives one byte per item; letters and digits form lowercase tokens, any other
// byte ends a token. Each term (unigram, bigram, trigram) goes through the shared
// bit-serial divider that finds the hash modulo the dimension, followed by a
// read-modify-write of the accumulator memory. A letter may add a trigram; a byte that
// ends a token adds its unigram and bigram. End of text adds the pending token terms,
// then sweeps the memory and takes the square root. A read goes through the divider
// unless the norm is zero or the index is out of range. A clear, and the clearing pass
// after reset, zero the memory while req_stall is high. One item is worked on at a
// time; a finished read result waits in the output register while the next item is
// taken.
module hashed_text_feature_vector_top #(
   parameter int MAX_DIMS = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [htfv_pkg::CMD_W-1:0]    req_command,
   input  logic [htfv_pkg::BYTE_W-1:0]   req_text_byte,
   input  logic [htfv_pkg::INDEX_W-1:0]  req_read_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [htfv_pkg::VALUE_W-1:0] rsp_element_value,
   output logic [htfv_pkg::INDEX_W-1:0]  rsp_element_index,
   input  logic                          csr_write_enable,
   input  logic [htfv_pkg::DIMS_W-1:0]   csr_write_data
);

   localparam int AW      = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam int DIV_N_W = 41;
   localparam int DIV_D_W = 32;
   localparam int PROD_W  = 50;

   localparam logic [4:0] S_CLEAR     = 5'd0;
   localparam logic [4:0] S_IDLE      = 5'd1;
   localparam logic [4:0] S_TOK_START = 5'd2;
   localparam logic [4:0] S_CHAR      = 5'd3;
   localparam logic [4:0] S_TRI2      = 5'd4;
   localparam logic [4:0] S_TRI3      = 5'd5;
   localparam logic [4:0] S_ADD_DIV   = 5'd6;
   localparam logic [4:0] S_ADD_WAIT  = 5'd7;
   localparam logic [4:0] S_ADD_RD    = 5'd8;
   localparam logic [4:0] S_ADD_WR    = 5'd9;
   localparam logic [4:0] S_NORM      = 5'd10;
   localparam logic [4:0] S_SQRT      = 5'd11;
   localparam logic [4:0] S_RD_MEM    = 5'd12;
   localparam logic [4:0] S_RD_DIV    = 5'd13;
   localparam logic [4:0] S_RD_WAIT   = 5'd14;
   localparam logic [4:0] S_RSP       = 5'd15;

   localparam logic [1:0] TERM_UNI = 2'd0;
   localparam logic [1:0] TERM_BI  = 2'd1;
   localparam logic [1:0] TERM_TRI = 2'd2;

   localparam logic [htfv_pkg::SUM_W-1:0] SQRT_BIT_TOP = 64'h4000_0000_0000_0000;

   // Control state.
   logic [4:0]                       state_ff, state_in;
   logic                             in_token_ff, in_token_in;
   logic                             have_prev_ff, have_prev_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [htfv_pkg::DIMS_W-1:0]      dims_ff, dims_in;
   logic [31:0]                      norm_ff, norm_in;
   htfv_pkg::hash_type               token_ff, token_in;
   htfv_pkg::hash_type               pair_ff, pair_in;
   htfv_pkg::hash_type               prev_ff, prev_in;
   logic [15:0]                      pos_ff, pos_in;
   logic [15:0]                      last2_ff, last2_in;
   logic [AW-1:0]                    clr_cnt_ff, clr_cnt_in;
   logic [AW:0]                      norm_i_ff, norm_i_in;
   logic                             v1_ff, v1_in;
   logic                             v2_ff, v2_in;

   // Working payload.
   logic [htfv_pkg::BYTE_W-1:0]      char_ff, char_in;
   logic [htfv_pkg::BYTE_W-1:0]      tri_b1_ff, tri_b1_in;
   htfv_pkg::hash_type               term_h_ff, term_h_in;
   logic [1:0]                       kind_ff, kind_in;
   logic                             end_cmd_ff, end_cmd_in;
   logic signed [PROD_W-1:0]         prod_ff, prod_in;
   logic signed [22:0]               term_ff, term_in;
   logic [AW-1:0]                    idx_ff, idx_in;
   logic [htfv_pkg::INDEX_W-1:0]     ridx_ff, ridx_in;
   logic                             neg_ff, neg_in;
   logic [63:0]                      sq_ff, sq_in;
   logic [htfv_pkg::SUM_W-1:0]       sum_ff, sum_in;
   logic [htfv_pkg::SUM_W-1:0]       sv_ff, sv_in;
   logic [htfv_pkg::SUM_W-1:0]       res_ff, res_in;
   logic [htfv_pkg::SUM_W-1:0]       bit_ff, bit_in;
   logic signed [htfv_pkg::VALUE_W-1:0] elem_val_ff, elem_val_in;
   logic signed [htfv_pkg::VALUE_W-1:0] out_val_ff, out_val_in;
   logic [htfv_pkg::INDEX_W-1:0]     out_idx_ff, out_idx_in;

   // Accumulator memory.
   htfv_pkg::acc_type                acc_mem [MAX_DIMS];
   htfv_pkg::acc_type                rd_data_ff;
   logic [AW-1:0]                    mem_raddr;
   logic [AW-1:0]                    mem_waddr;
   htfv_pkg::acc_type                mem_wdata;
   logic                             mem_we;

   // Divider.
   logic                             div_start;
   logic [DIV_N_W-1:0]               div_num;
   logic [DIV_D_W-1:0]               div_den;
   logic                             div_busy;
   logic [DIV_N_W-1:0]               div_q;
   logic [DIV_D_W-1:0]               div_r;

   logic [htfv_pkg::DIMS_W-1:0]      eff_dims;
   logic                             accept;
   logic                             is_digit, is_lower, is_upper;
   logic [htfv_pkg::BYTE_W-1:0]      low_char;
   logic signed [32:0]               acc_sum;
   htfv_pkg::acc_type                acc_sat;
   htfv_pkg::acc_type                mag;
   logic [htfv_pkg::SUM_W-1:0]       sqrt_trial;
   htfv_pkg::weight_type             weight;
   logic signed [PROD_W-1:0]         prod_round;

   htfv_divider #(
      .NUM_W (DIV_N_W),
      .DEN_W (DIV_D_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .numerator   (div_num),
      .denominator (div_den),
      .busy        (div_busy),
      .quotient    (div_q),
      .remainder   (div_r)
   );

   always_comb begin
      if (dims_ff == '0) begin
         eff_dims = htfv_pkg::DIMS_W'(1);
      end else if (32'(dims_ff) > MAX_DIMS) begin
         eff_dims = htfv_pkg::DIMS_W'(MAX_DIMS);
      end else begin
         eff_dims = dims_ff;
      end
   end

   always_comb begin
      is_digit = (req_text_byte >= 8'h30) && (req_text_byte <= 8'h39);
      is_lower = (req_text_byte >= 8'h61) && (req_text_byte <= 8'h7A);
      is_upper = (req_text_byte >= 8'h41) && (req_text_byte <= 8'h5A);
      low_char = is_upper ? req_text_byte + 8'h20 : req_text_byte;
   end

   always_comb begin
      case (kind_ff)
         TERM_UNI: weight = htfv_pkg::W_ONE;
         TERM_BI:  weight = htfv_pkg::W_BIGRAM;
         default:  weight = htfv_pkg::W_TRIGRAM;
      endcase
   end

   assign accept     = req_valid && (state_ff == S_IDLE);
   assign prod_round = prod_ff + PROD_W'(64'sd67108864);
   assign acc_sum    = {rd_data_ff[31], rd_data_ff} + 33'(term_ff);
   assign mag        = rd_data_ff[31] ? 32'(-rd_data_ff) : rd_data_ff;
   assign sqrt_trial = res_ff + bit_ff;

   always_comb begin
      if (acc_sum > 33'sd2147483647) begin
         acc_sat = 32'h7FFF_FFFF;
      end else if (acc_sum < -33'sd2147483648) begin
         acc_sat = 32'h8000_0000;
      end else begin
         acc_sat = acc_sum[31:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      in_token_in  = in_token_ff;
      have_prev_in = have_prev_ff;
      dims_in      = csr_write_enable ? csr_write_data : dims_ff;
      norm_in      = norm_ff;
      token_in     = token_ff;
      pair_in      = pair_ff;
      prev_in      = prev_ff;
      pos_in       = pos_ff;
      last2_in     = last2_ff;
      clr_cnt_in   = clr_cnt_ff;
      norm_i_in    = norm_i_ff;
      v1_in        = v1_ff;
      v2_in        = v2_ff;
      char_in      = char_ff;
      tri_b1_in    = tri_b1_ff;
      term_h_in    = term_h_ff;
      kind_in      = kind_ff;
      end_cmd_in   = end_cmd_ff;
      prod_in      = prod_ff;
      term_in      = prod_round[PROD_W-1:27];
      idx_in       = idx_ff;
      ridx_in      = ridx_ff;
      neg_in       = neg_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      sv_in        = sv_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      elem_val_in  = elem_val_ff;
      out_val_in   = out_val_ff;
      out_idx_in   = out_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_raddr    = idx_ff;
      mem_waddr    = idx_ff;
      mem_wdata    = acc_sat;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      div_num      = DIV_N_W'(term_h_ff);
      div_den      = DIV_D_W'(eff_dims);

      case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_ff;
            mem_wdata = '0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(MAX_DIMS - 1)) begin
               clr_cnt_in   = '0;
               state_in     = S_IDLE;
               norm_in      = '0;
               token_in     = htfv_pkg::FNV_BASIS;
               pair_in      = htfv_pkg::FNV_BASIS;
               prev_in      = '0;
               have_prev_in = 1'b0;
               in_token_in  = 1'b0;
               pos_in       = '0;
               last2_in     = '0;
            end
         end
         S_IDLE: begin
            if (accept) begin
               end_cmd_in = req_command == htfv_pkg::CMD_END;
               ridx_in    = req_read_index;
               char_in    = low_char;
               case (req_command)
                  htfv_pkg::CMD_BYTE: begin
                     if (is_digit || is_lower || is_upper) begin
                        state_in = in_token_ff ? S_CHAR : S_TOK_START;
                     end else if (in_token_ff) begin
                        term_h_in = token_ff;
                        kind_in   = TERM_UNI;
                        state_in  = S_ADD_DIV;
                     end
                  end
                  htfv_pkg::CMD_END: begin
                     if (in_token_ff) begin
                        term_h_in = token_ff;
                        kind_in   = TERM_UNI;
                        state_in  = S_ADD_DIV;
                     end else begin
                        norm_i_in = '0;
                        sum_in    = '0;
                        v1_in     = 1'b0;
                        v2_in     = 1'b0;
                        state_in  = S_NORM;
                     end
                  end
                  htfv_pkg::CMD_READ: begin
                     if ((32'(req_read_index) < MAX_DIMS) && (norm_ff != '0)) begin
                        state_in = S_RD_MEM;
                     end else begin
                        elem_val_in = '0;
                        state_in    = S_RSP;
                     end
                  end
                  htfv_pkg::CMD_CLEAR: begin
                     clr_cnt_in = '0;
                     state_in   = S_CLEAR;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_TOK_START: begin
            token_in    = htfv_pkg::FNV_BASIS;
            pair_in     = have_prev_ff ? htfv_pkg::fnv_step(prev_ff, htfv_pkg::CHAR_UNDERSCORE)
                                       : htfv_pkg::CARET_PAIR_HASH;
            pos_in      = '0;
            last2_in    = '0;
            in_token_in = 1'b1;
            state_in    = S_CHAR;
         end
         S_CHAR: begin
            token_in = htfv_pkg::fnv_step(token_ff, char_ff);
            pair_in  = htfv_pkg::fnv_step(pair_ff, char_ff);
            last2_in = {last2_ff[7:0], char_ff};
            if (pos_ff != 16'hFFFF) begin
               pos_in = pos_ff + 1'b1;
            end
            // Trigrams start at even offsets; the saturated position is odd.
            if ((pos_ff >= 16'd2) && !pos_ff[0]) begin
               term_h_in = htfv_pkg::fnv_step(htfv_pkg::FNV_BASIS, last2_ff[15:8]);
               tri_b1_in = last2_ff[7:0];
               state_in  = S_TRI2;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_TRI2: begin
            term_h_in = htfv_pkg::fnv_step(term_h_ff, tri_b1_ff);
            state_in  = S_TRI3;
         end
         S_TRI3: begin
            term_h_in = htfv_pkg::fnv_step(term_h_ff, char_ff);
            kind_in   = TERM_TRI;
            state_in  = S_ADD_DIV;
         end
         S_ADD_DIV: begin
            div_start = 1'b1;
            prod_in   = $signed(term_h_ff) * $signed({1'b0, weight});
            state_in  = S_ADD_WAIT;
         end
         S_ADD_WAIT: begin
            if (!div_busy) begin
               idx_in   = div_r[AW-1:0];
               state_in = S_ADD_RD;
            end
         end
         S_ADD_RD: begin
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            mem_we = 1'b1;
            case (kind_ff)
               TERM_UNI: begin
                  term_h_in = pair_ff;
                  kind_in   = TERM_BI;
                  state_in  = S_ADD_DIV;
               end
               TERM_BI: begin
                  prev_in      = token_ff;
                  have_prev_in = 1'b1;
                  in_token_in  = 1'b0;
                  if (end_cmd_ff) begin
                     norm_i_in = '0;
                     sum_in    = '0;
                     v1_in     = 1'b0;
                     v2_in     = 1'b0;
                     state_in  = S_NORM;
                  end else begin
                     state_in = S_IDLE;
                  end
               end
               default: state_in = S_IDLE;
            endcase
         end
         S_NORM: begin
            // Three-stage sweep: read, square, accumulate.
            mem_raddr = norm_i_ff[AW-1:0];
            v1_in     = 1'b0;
            if (32'(norm_i_ff) < 32'(eff_dims)) begin
               v1_in     = 1'b1;
               norm_i_in = norm_i_ff + 1'b1;
            end
            v2_in = v1_ff;
            if (v1_ff) begin
               sq_in = 64'($signed(rd_data_ff) * $signed(rd_data_ff));
            end
            if (v2_ff) begin
               sum_in = sum_ff + {12'b0, sq_ff[63:12]};
            end
            if ((32'(norm_i_ff) >= 32'(eff_dims)) && !v1_ff && !v2_ff) begin
               sv_in    = sum_ff;
               res_in   = '0;
               bit_in   = SQRT_BIT_TOP;
               state_in = S_SQRT;
            end
         end
         S_SQRT: begin
            if (bit_ff == '0) begin
               norm_in      = res_ff[31:0];
               token_in     = htfv_pkg::FNV_BASIS;
               pair_in      = htfv_pkg::FNV_BASIS;
               prev_in      = '0;
               have_prev_in = 1'b0;
               in_token_in  = 1'b0;
               pos_in       = '0;
               last2_in     = '0;
               state_in     = S_IDLE;
            end else begin
               if (sv_ff >= sqrt_trial) begin
                  sv_in  = sv_ff - sqrt_trial;
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in = bit_ff >> 2;
            end
         end
         S_RD_MEM: begin
            mem_raddr = AW'(ridx_ff);
            state_in  = S_RD_DIV;
         end
         S_RD_DIV: begin
            div_start = 1'b1;
            div_num   = (DIV_N_W'(mag) << 9) + DIV_N_W'(norm_ff[31:1]);
            div_den   = norm_ff;
            neg_in    = rd_data_ff[31];
            state_in  = S_RD_WAIT;
         end
         S_RD_WAIT: begin
            if (!div_busy) begin
               if (neg_ff) begin
                  elem_val_in = (div_q > DIV_N_W'(32768)) ? 16'sh8000
                                                          : 16'(-div_q[15:0]);
               end else begin
                  elem_val_in = (div_q > DIV_N_W'(32767)) ? 16'sh7FFF : div_q[15:0];
               end
               state_in = S_RSP;
            end
         end
         S_RSP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_val_in   = elem_val_ff;
               out_idx_in   = ridx_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         in_token_ff  <= 1'b0;
         have_prev_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dims_ff      <= htfv_pkg::DIMS_RESET;
         norm_ff      <= '0;
         token_ff     <= htfv_pkg::FNV_BASIS;
         pair_ff      <= htfv_pkg::FNV_BASIS;
         prev_ff      <= '0;
         pos_ff       <= '0;
         last2_ff     <= '0;
         clr_cnt_ff   <= '0;
         norm_i_ff    <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_token_ff  <= in_token_in;
         have_prev_ff <= have_prev_in;
         rsp_valid_ff <= rsp_valid_in;
         dims_ff      <= dims_in;
         norm_ff      <= norm_in;
         token_ff     <= token_in;
         pair_ff      <= pair_in;
         prev_ff      <= prev_in;
         pos_ff       <= pos_in;
         last2_ff     <= last2_in;
         clr_cnt_ff   <= clr_cnt_in;
         norm_i_ff    <= norm_i_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff     <= char_in;
      tri_b1_ff   <= tri_b1_in;
      term_h_ff   <= term_h_in;
      kind_ff     <= kind_in;
      end_cmd_ff  <= end_cmd_in;
      prod_ff     <= prod_in;
      term_ff     <= term_in;
      idx_ff      <= idx_in;
      ridx_ff     <= ridx_in;
      neg_ff      <= neg_in;
      sq_ff       <= sq_in;
      sum_ff      <= sum_in;
      sv_ff       <= sv_in;
      res_ff      <= res_in;
      bit_ff      <= bit_in;
      elem_val_ff <= elem_val_in;
      out_val_ff  <= out_val_in;
      out_idx_ff  <= out_idx_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         acc_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= acc_mem[mem_raddr];
   end

   assign req_stall         = state_ff != S_IDLE;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_element_value = out_val_ff;
   assign rsp_element_index = out_idx_ff;

endmodule

// File: hdl/htfv_divider.sv
// Restoring divider, one quotient bit per cycle, for hash modulo and element scaling.
// No package dependencies.
module htfv_divider #(
   parameter int NUM_W = 41,
   parameter int DEN_W = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] numerator,
   input  logic [DEN_W-1:0] denominator,
   output logic             busy,
   output logic [NUM_W-1:0] quotient,
   output logic [DEN_W-1:0] remainder
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             fits;

   always_comb begin
      trial = {rem_ff, num_ff[NUM_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= numerator;
         rem_ff <= '0;
         den_ff <= denominator;
      end else if (cnt_ff != '0) begin
         rem_ff <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         num_ff <= {num_ff[NUM_W-2:0], fits};
      end
   end

   assign busy      = cnt_ff != '0;
   assign quotient  = num_ff;
   assign remainder = rem_ff;

endmodule

// File: sim/hashed_text_feature_vector_top_test.sv
// Self-checking testbench for hashed_text_feature_vector_top: directed and random text,
// end of text, reads and clears, checked against a behavioral predictor of the vector.
// Depends on htfv_pkg and the hashed_text_feature_vector_top RTL.
module hashed_text_feature_vector_top_test;

   localparam int VEC_DEPTH   = 4096;
   localparam int SETTLE_WAIT = 5000;

   typedef struct {
      logic signed [htfv_pkg::VALUE_W-1:0] value;
      logic [htfv_pkg::INDEX_W-1:0]        index;
   } element_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [htfv_pkg::CMD_W-1:0]    req_command = htfv_pkg::CMD_BYTE;
   logic [htfv_pkg::BYTE_W-1:0]   req_text_byte = '0;
   logic [htfv_pkg::INDEX_W-1:0]  req_read_index = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic signed [htfv_pkg::VALUE_W-1:0] rsp_element_value;
   logic [htfv_pkg::INDEX_W-1:0]  rsp_element_index;
   logic                csr_write_enable = 1'b0;
   logic [htfv_pkg::DIMS_W-1:0]   csr_write_data = '0;

   hashed_text_feature_vector_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_text_byte(req_text_byte), .req_read_index(req_read_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_element_value(rsp_element_value), .rsp_element_index(rsp_element_index),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   // Predicted state of the feature vector.
   int          acc_mem [VEC_DEPTH];
   htfv_pkg::hash_type tok_hash, pair_hash, prev_tok_hash;
   bit          have_prev, in_tok;
   int unsigned char_pos;
   bit [15:0]   last_two;
   bit [31:0]   norm_q14;
   bit [htfv_pkg::DIMS_W-1:0] dims_reg;

   element_type pending_elements[$];
   int errors = 0;
   int items_sent = 0;
   int reads_checked = 0;
   int burst_left = 0;

   function automatic htfv_pkg::hash_type hash_byte(htfv_pkg::hash_type h, logic [7:0] b);
      logic [63:0] p;
      p = {32'b0, h ^ {24'b0, b}} * {32'b0, htfv_pkg::FNV_PRIME};
      return p[31:0];
   endfunction

   function automatic int unsigned active_dims();
      if (dims_reg == 0) return 1;
      if (dims_reg > VEC_DEPTH) return VEC_DEPTH;
      return dims_reg;
   endfunction

   function automatic void accumulate(htfv_pkg::hash_type h, longint w);
      int unsigned idx;
      longint hs, x, s;
      idx = h % active_dims();
      hs = longint'($signed(h));
      x = hs * w + (64'sd1 <<< 26);
      s = longint'(acc_mem[idx]) + (x >>> 27);
      if (s > 64'sd2147483647) s = 64'sd2147483647;
      if (s < -64'sd2147483648) s = -64'sd2147483648;
      acc_mem[idx] = int'(s);
   endfunction

   function automatic void restart_tokens();
      tok_hash = htfv_pkg::FNV_BASIS;
      pair_hash = htfv_pkg::FNV_BASIS;
      prev_tok_hash = '0;
      have_prev = 0;
      in_tok = 0;
      char_pos = 0;
      last_two = '0;
   endfunction

   function automatic void close_token();
      if (!in_tok) return;
      accumulate(tok_hash, htfv_pkg::W_ONE);
      accumulate(pair_hash, htfv_pkg::W_BIGRAM);
      prev_tok_hash = tok_hash;
      have_prev = 1;
      in_tok = 0;
   endfunction

   function automatic void add_char(logic [7:0] c);
      htfv_pkg::hash_type t;
      if (!in_tok) begin
         tok_hash = htfv_pkg::FNV_BASIS;
         pair_hash = have_prev ? hash_byte(prev_tok_hash, htfv_pkg::CHAR_UNDERSCORE)
                               : hash_byte(hash_byte(htfv_pkg::FNV_BASIS, htfv_pkg::CHAR_CARET),
                                           htfv_pkg::CHAR_UNDERSCORE);
         char_pos = 0;
         last_two = '0;
         in_tok = 1;
      end
      tok_hash = hash_byte(tok_hash, c);
      pair_hash = hash_byte(pair_hash, c);
      if (char_pos >= 2 && char_pos[0] == 1'b0) begin
         t = hash_byte(htfv_pkg::FNV_BASIS, last_two[15:8]);
         t = hash_byte(t, last_two[7:0]);
         t = hash_byte(t, c);
         accumulate(t, htfv_pkg::W_TRIGRAM);
      end
      last_two = {last_two[7:0], c};
      if (char_pos < 32'hFFFF) char_pos++;
   endfunction

   function automatic bit [31:0] int_sqrt(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res[31:0];
   endfunction

   function automatic void compute_norm();
      bit [63:0] sum;
      longint a;
      sum = 0;
      for (int i = 0; i < active_dims(); i++) begin
         a = acc_mem[i];
         sum += 64'(a * a) >> 12;
      end
      norm_q14 = int_sqrt(sum);
   endfunction

   function automatic element_type read_element(logic [htfv_pkg::INDEX_W-1:0] idx);
      element_type e;
      longint a;
      bit [63:0] mag, q;
      e.index = idx;
      e.value = '0;
      if (norm_q14 != 0) begin
         a = acc_mem[idx];
         mag = (a < 0) ? 64'(-a) : 64'(a);
         q = (mag * 512 + (norm_q14 >> 1)) / norm_q14;
         if (a < 0) e.value = (q > 32768) ? -16'sd32768 : 16'(-$signed(q[16:0]));
         else e.value = (q > 32767) ? 16'sd32767 : q[15:0];
      end
      return e;
   endfunction

   // Applies one accepted item to the predicted state.
   function automatic void predict_item(logic [htfv_pkg::CMD_W-1:0] cmd, logic [7:0] b,
                                        logic [htfv_pkg::INDEX_W-1:0] idx);
      case (cmd)
         htfv_pkg::CMD_BYTE: begin
            if ((b >= "0" && b <= "9") || (b >= "a" && b <= "z")) add_char(b);
            else if (b >= "A" && b <= "Z") add_char(b + 8'd32);
            else close_token();
         end
         htfv_pkg::CMD_END: begin
            close_token();
            compute_norm();
            restart_tokens();
         end
         htfv_pkg::CMD_CLEAR: begin
            foreach (acc_mem[i]) acc_mem[i] = 0;
            restart_tokens();
            norm_q14 = '0;
         end
         default: pending_elements = {pending_elements, read_element(idx)};
      endcase
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
   endtask

   task automatic send_item(logic [htfv_pkg::CMD_W-1:0] cmd, logic [7:0] b = 8'h00,
                            logic [htfv_pkg::INDEX_W-1:0] idx = '0);
      bit stalled;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_command <= cmd;
      req_text_byte <= b;
      req_read_index <= idx;
      req_valid <= 1'b1;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      predict_item(cmd, b, idx);
      items_sent++;
   endtask

   task automatic send_word(string s);
      for (int i = 0; i < s.len(); i++) send_item(htfv_pkg::CMD_BYTE, s[i]);
   endtask

   // Holds the sender until every read result is back and the block has gone quiet.
   task automatic drain(int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_elements.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic set_dims(logic [htfv_pkg::DIMS_W-1:0] v);
      drain(SETTLE_WAIT);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      dims_reg = v;
   endtask

   task automatic read_some(int n, int unsigned hi);
      for (int i = 0; i < n; i++)
         send_item(htfv_pkg::CMD_READ, 8'h00, htfv_pkg::INDEX_W'($urandom_range(0, hi)));
   endtask

   // Receiver stall pattern: cycles through free flow, light, heavy and periodic stalls.
   int unsigned rx_cycle = 0;
   always @(posedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (reset) rsp_stall <= 1'b0;
      else begin
         case ((rx_cycle >> 9) % 4)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 1) == 0);
            2: rsp_stall <= ($urandom_range(0, 3) != 0);
            default: rsp_stall <= ((rx_cycle % 7) < 3);
         endcase
      end
   end

   // Result checker; values are sampled mid-cycle ahead of the accepting edge.
   always @(negedge clock) begin
      element_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_elements.size() == 0) begin
            report_mismatch($sformatf("unexpected element index %0d", rsp_element_index));
         end else begin
            e = pending_elements.pop_front();
            reads_checked++;
            if (rsp_element_index !== e.index)
               report_mismatch($sformatf("element_index %0d, expected %0d",
                                         rsp_element_index, e.index));
            if (rsp_element_value !== e.value)
               report_mismatch($sformatf("element_value %0d at %0d, expected %0d",
                                         rsp_element_value, e.index, e.value));
         end
      end
   end

   task automatic test_directed();
      send_item(htfv_pkg::CMD_READ, 8'h00, 12'd0);         // zero norm before any text
      send_item(htfv_pkg::CMD_READ, 8'h00, 12'd4095);
      send_word("Hello, WORLD 09 az");
      send_item(htfv_pkg::CMD_BYTE, 8'h00);
      send_item(htfv_pkg::CMD_BYTE, 8'hFF);
      send_word("Zq");
      read_some(2, active_dims() - 1);           // read before the norm exists
      send_item(htfv_pkg::CMD_END);              // token in progress is closed first
      send_item(htfv_pkg::CMD_END);
      read_some(4, active_dims() - 1);
      send_item(htfv_pkg::CMD_READ, 8'h00, 12'd4095);
      send_item(htfv_pkg::CMD_CLEAR);
      send_item(htfv_pkg::CMD_READ, 8'h00, 12'd1);
      drain(0);
   endtask

   task automatic test_dims_range();
      logic [htfv_pkg::DIMS_W-1:0] settings[4] = '{13'd0, 13'd1, 13'd4096, 13'd8191};
      foreach (settings[k]) begin
         set_dims(settings[k]);
         send_item(htfv_pkg::CMD_CLEAR);
         send_word("the quick brown fox ");
         send_item(htfv_pkg::CMD_END);
         read_some(3, VEC_DEPTH - 1);
         send_item(htfv_pkg::CMD_READ, 8'h00, 12'd0);
      end
   endtask

   task automatic test_random();
      logic [htfv_pkg::DIMS_W-1:0] phase_dims[4];
      int unsigned r, hi;
      phase_dims = '{13'd1, 13'($urandom_range(2, 64)), 13'($urandom_range(65, 4095)), 13'd4096};
      foreach (phase_dims[p]) begin
         set_dims(phase_dims[p]);
         hi = active_dims() - 1;
         for (int i = 0; i < 65; i++) begin
            r = $urandom_range(0, 99);
            if (r < 55) send_item(htfv_pkg::CMD_BYTE, 8'(8'h61 + $urandom_range(0, 25)));
            else if (r < 62) send_item(htfv_pkg::CMD_BYTE, 8'(8'h41 + $urandom_range(0, 25)));
            else if (r < 66) send_item(htfv_pkg::CMD_BYTE, 8'(8'h30 + $urandom_range(0, 9)));
            else if (r < 74) send_item(htfv_pkg::CMD_BYTE, " ");
            else if (r < 77) send_item(htfv_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
            else if (r < 83) send_item(htfv_pkg::CMD_END);
            else if (r < 85) send_item(htfv_pkg::CMD_CLEAR);
            else if (r < 97)
               send_item(htfv_pkg::CMD_READ, 8'h00, htfv_pkg::INDEX_W'($urandom_range(0, hi)));
            else
               send_item(htfv_pkg::CMD_READ, 8'h00,
                         htfv_pkg::INDEX_W'($urandom_range(0, VEC_DEPTH - 1)));
         end
         send_item(htfv_pkg::CMD_END);
         read_some(6, hi);
      end
   endtask

   initial begin
      foreach (acc_mem[i]) acc_mem[i] = 0;
      restart_tokens();
      norm_q14 = '0;
      dims_reg = htfv_pkg::DIMS_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);   // clearing pass after reset
      test_directed();
      test_dims_range();
      test_random();
      drain(SETTLE_WAIT);
      $display("Sent %0d items and checked %0d element reads", items_sent, reads_checked);
      $display("Covered dimension extremes, reads before and after the norm, and random text");
      if (errors == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #40000000;
      $display("Timeout with %0d reads outstanding", pending_elements.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
